// ----- rtl/btc_pkg.sv -----
// Shared types and constants for the barometric temperature compensation block.
// Payload structs, calibration register set, register indexes and range limits.
// No dependencies.
package btc_pkg;

   localparam int RAW_W       = 24;
   localparam int COEF_W      = 16;
   localparam int CSR_INDEX_W = 3;

   // Calibration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_SENS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_OFFSET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENS_TEMPCO   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_TEMPCO = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_TEMP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_SLOPE    = 3'd5;

   // Correction level codes
   localparam logic [1:0] LEVEL_NONE       = 2'd0;
   localparam logic [1:0] LEVEL_BELOW_20C  = 2'd1;
   localparam logic [1:0] LEVEL_BELOW_M15C = 2'd2;

   // Temperature thresholds and limits, hundredths of a degree
   localparam logic signed [19:0] TEMP_REF_CENTI = 20'sd2000;
   localparam logic signed [19:0] TEMP_LOW_CENTI = -20'sd1500;
   localparam logic signed [19:0] TEMP_MIN_CENTI = -20'sd4000;
   localparam logic signed [19:0] TEMP_MAX_CENTI = 20'sd8500;

   // Pressure limits, pascal
   localparam logic signed [30:0] PRESS_MIN_PA = 31'sd1000;
   localparam logic signed [30:0] PRESS_MAX_PA = 31'sd120000;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [16:0]        pressure_pa;
      logic [1:0]         correction_level;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef_press_sens;
      logic [COEF_W-1:0] coef_press_offset;
      logic [COEF_W-1:0] coef_sens_tempco;
      logic [COEF_W-1:0] coef_offset_tempco;
      logic [COEF_W-1:0] coef_ref_temp;
      logic [COEF_W-1:0] coef_temp_slope;
   } coef_type;

endpackage

// ----- rtl/btc_csr.sv -----
// Calibration register file for the temperature compensation block.
// Six 16-bit write-only words; depends on btc_pkg.
module btc_csr import btc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata,
   output coef_type               coef
);

   coef_type coef_ff, coef_in;

   // Decode the write index; unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PRESS_SENS:    coef_in.coef_press_sens    = csr_wdata;
            CSR_PRESS_OFFSET:  coef_in.coef_press_offset  = csr_wdata;
            CSR_SENS_TEMPCO:   coef_in.coef_sens_tempco   = csr_wdata;
            CSR_OFFSET_TEMPCO: coef_in.coef_offset_tempco = csr_wdata;
            CSR_REF_TEMP:      coef_in.coef_ref_temp      = csr_wdata;
            CSR_TEMP_SLOPE:    coef_in.coef_temp_slope    = csr_wdata;
            default:           coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ----- rtl/baro_temp_compensation.sv -----
// Barometric sensor temperature compensation, top level.
// Ten-stage compensation pipeline; depends on btc_pkg and btc_csr.
//
// Takes one raw pressure/temperature conversion pair per beat and returns the
// compensated temperature (0.01 degC), pressure (Pa), the low-temperature
// correction level and a saturation flag. Fully pipelined: a new pair can be
// accepted every clock cycle unless a stall on rsp_ready has backed up to the
// first stage. The ten register stages are offset, multiplies, first-order
// terms, squares, second-order terms, final OFF/SENS with temperature
// saturation, the split 24x41 pressure multiply and its combining shift, the
// OFF subtraction with scaling, and output saturation. A stall on rsp_ready
// backs up only through full stages, so bubbles are squeezed out. Calibration
// words are written through the csr_ port and must only change while no beat is in flight.
module baro_temp_compensation import btc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata
);

   localparam int NUM_STAGES = 10;

   coef_type coef;

   btc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // ---------------------------------------------------------------------
   // Pipeline control: a stage advances when empty or when the next advances
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------------
   // Stage 1: dT = D2 - reftemp*256
   // ---------------------------------------------------------------------
   logic signed [24:0] dt_ff, dt_in;
   logic [RAW_W-1:0]   d1_s1_ff;

   assign dt_in = $signed({1'b0, req_data.raw_temperature})
                - $signed({1'b0, coef.coef_ref_temp, 8'h00});

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= req_data.raw_pressure;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: products of dT with the coefficients and with itself
   // ---------------------------------------------------------------------
   logic signed [41:0] pt_ff, pt_in, poff_ff, poff_in, psens_ff, psens_in;
   logic signed [49:0] dsq_ff, dsq_in;
   logic [RAW_W-1:0]   d1_s2_ff;

   assign pt_in    = dt_ff * $signed({1'b0, coef.coef_temp_slope});
   assign poff_in  = dt_ff * $signed({1'b0, coef.coef_offset_tempco});
   assign psens_in = dt_ff * $signed({1'b0, coef.coef_sens_tempco});
   assign dsq_in   = dt_ff * dt_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pt_ff    <= pt_in;
         poff_ff  <= poff_in;
         psens_ff <= psens_in;
         dsq_ff   <= dsq_in;
         d1_s2_ff <= d1_s1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: first-order TEMP, OFF, SENS and the T2 term (floor shifts)
   // ---------------------------------------------------------------------
   logic signed [19:0] temp_s3_ff, temp_s3_in;
   logic signed [35:0] off_s3_ff, off_s3_in, sens_s3_ff, sens_s3_in;
   logic [18:0]        t2_s3_ff;
   logic [RAW_W-1:0]   d1_s3_ff;

   assign temp_s3_in = $signed(pt_ff[41:23]) + TEMP_REF_CENTI;
   assign off_s3_in  = $signed({4'b0, coef.coef_press_offset, 16'h0000})
                     + $signed(poff_ff[41:7]);
   assign sens_s3_in = $signed({5'b0, coef.coef_press_sens, 15'h0000})
                     + $signed(psens_ff[41:8]);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         temp_s3_ff <= temp_s3_in;
         off_s3_ff  <= off_s3_in;
         sens_s3_ff <= sens_s3_in;
         t2_s3_ff   <= dsq_ff[49:31];
         d1_s3_ff   <= d1_s2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: threshold compares and the squared deviations
   // ---------------------------------------------------------------------
   logic signed [19:0] xdev, ydev;
   logic signed [39:0] asq_full, bsq_full;
   logic [34:0]        asq_ff, bsq_ff;
   logic               lt20_ff, lt15_ff;
   logic signed [19:0] temp_s4_ff;
   logic signed [35:0] off_s4_ff, sens_s4_ff;
   logic [18:0]        t2_s4_ff;
   logic [RAW_W-1:0]   d1_s4_ff;

   assign xdev     = temp_s3_ff - TEMP_REF_CENTI;
   assign ydev     = temp_s3_ff - TEMP_LOW_CENTI;
   assign asq_full = xdev * xdev;
   assign bsq_full = ydev * ydev;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         asq_ff     <= asq_full[34:0];
         bsq_ff     <= bsq_full[34:0];
         lt20_ff    <= temp_s3_ff < TEMP_REF_CENTI;
         lt15_ff    <= temp_s3_ff < TEMP_LOW_CENTI;
         temp_s4_ff <= temp_s3_ff;
         off_s4_ff  <= off_s3_ff;
         sens_s4_ff <= sens_s3_ff;
         t2_s4_ff   <= t2_s3_ff;
         d1_s4_ff   <= d1_s3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: second-order OFF2/SENS2, TEMP - T2, correction level
   // ---------------------------------------------------------------------
   logic [37:0]        a5, b7;
   logic [38:0]        b11;
   logic [38:0]        off2_ff, off2_in, sens2_ff, sens2_in;
   logic signed [19:0] temp_s5_ff, temp_s5_in;
   logic [1:0]         level_s5_ff, level_s5_in;
   logic signed [35:0] off_s5_ff, sens_s5_ff;
   logic [RAW_W-1:0]   d1_s5_ff;

   assign a5  = {1'b0, asq_ff, 2'b00} + {3'b000, asq_ff};
   assign b7  = {bsq_ff, 3'b000} - {3'b000, bsq_ff};
   assign b11 = {1'b0, bsq_ff, 3'b000} + {3'b000, bsq_ff, 1'b0} + {4'b0000, bsq_ff};

   always_comb begin
      off2_in     = '0;
      sens2_in    = '0;
      temp_s5_in  = temp_s4_ff;
      level_s5_in = LEVEL_NONE;
      if (lt20_ff) begin
         off2_in     = {2'b00, a5[37:1]};
         sens2_in    = {3'b000, a5[37:2]};
         temp_s5_in  = temp_s4_ff - $signed({1'b0, t2_s4_ff});
         level_s5_in = LEVEL_BELOW_20C;
         if (lt15_ff) begin
            off2_in     = {2'b00, a5[37:1]} + {1'b0, b7};
            sens2_in    = {3'b000, a5[37:2]} + {1'b0, b11[38:1]};
            level_s5_in = LEVEL_BELOW_M15C;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         off2_ff     <= off2_in;
         sens2_ff    <= sens2_in;
         temp_s5_ff  <= temp_s5_in;
         level_s5_ff <= level_s5_in;
         off_s5_ff   <= off_s4_ff;
         sens_s5_ff  <= sens_s4_ff;
         d1_s5_ff    <= d1_s4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: final OFF and SENS, temperature saturation
   // ---------------------------------------------------------------------
   logic signed [40:0] off_s6_ff, off_s6_in, sens_s6_ff, sens_s6_in;
   logic signed [19:0] temp_sat;
   logic               tflag;
   logic signed [14:0] temp_s6_ff;
   logic               tflag_s6_ff;
   logic [1:0]         level_s6_ff;
   logic [RAW_W-1:0]   d1_s6_ff;

   assign off_s6_in  = off_s5_ff - $signed({2'b00, off2_ff});
   assign sens_s6_in = sens_s5_ff - $signed({2'b00, sens2_ff});

   always_comb begin
      temp_sat = temp_s5_ff;
      tflag    = 1'b0;
      if (temp_s5_ff < TEMP_MIN_CENTI) begin
         temp_sat = TEMP_MIN_CENTI;
         tflag    = 1'b1;
      end else if (temp_s5_ff > TEMP_MAX_CENTI) begin
         temp_sat = TEMP_MAX_CENTI;
         tflag    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         off_s6_ff   <= off_s6_in;
         sens_s6_ff  <= sens_s6_in;
         temp_s6_ff  <= $signed(temp_sat[14:0]);
         tflag_s6_ff <= tflag;
         level_s6_ff <= level_s5_ff;
         d1_s6_ff    <= d1_s5_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: D1*SENS as two partial products (low 20 bits, signed high part)
   // ---------------------------------------------------------------------
   logic [43:0]        pp_lo_ff, pp_lo_in;
   logic signed [45:0] pp_hi_ff, pp_hi_in;
   logic signed [40:0] off_s7_ff;
   logic signed [14:0] temp_s7_ff;
   logic               tflag_s7_ff;
   logic [1:0]         level_s7_ff;

   assign pp_lo_in = d1_s6_ff * sens_s6_ff[19:0];
   assign pp_hi_in = $signed({1'b0, d1_s6_ff}) * $signed(sens_s6_ff[40:20]);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         pp_lo_ff    <= pp_lo_in;
         pp_hi_ff    <= pp_hi_in;
         off_s7_ff   <= off_s6_ff;
         temp_s7_ff  <= temp_s6_ff;
         tflag_s7_ff <= tflag_s6_ff;
         level_s7_ff <= level_s6_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 8: combine partial products, floor shift by 21
   // ---------------------------------------------------------------------
   logic signed [65:0] prod;
   logic signed [44:0] q_ff;
   logic signed [40:0] off_s8_ff;
   logic signed [14:0] temp_s8_ff;
   logic               tflag_s8_ff;
   logic [1:0]         level_s8_ff;

   assign prod = $signed({pp_hi_ff, 20'h00000}) + $signed({22'b0, pp_lo_ff});

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         q_ff        <= prod[65:21];
         off_s8_ff   <= off_s7_ff;
         temp_s8_ff  <= temp_s7_ff;
         tflag_s8_ff <= tflag_s7_ff;
         level_s8_ff <= level_s7_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 9: subtract OFF, floor shift by 15
   // ---------------------------------------------------------------------
   logic signed [45:0] pdiff;
   logic signed [30:0] pres_ff;
   logic signed [14:0] temp_s9_ff;
   logic               tflag_s9_ff;
   logic [1:0]         level_s9_ff;

   assign pdiff = q_ff - off_s8_ff;

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         pres_ff     <= pdiff[45:15];
         temp_s9_ff  <= temp_s8_ff;
         tflag_s9_ff <= tflag_s8_ff;
         level_s9_ff <= level_s8_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 10: pressure saturation into the output register
   // ---------------------------------------------------------------------
   rsp_type            rsp_ff, rsp_in;
   logic signed [30:0] pres_sat;
   logic               pflag;

   always_comb begin
      pres_sat = pres_ff;
      pflag    = 1'b0;
      if (pres_ff < PRESS_MIN_PA) begin
         pres_sat = PRESS_MIN_PA;
         pflag    = 1'b1;
      end else if (pres_ff > PRESS_MAX_PA) begin
         pres_sat = PRESS_MAX_PA;
         pflag    = 1'b1;
      end
      rsp_in.temperature_centi = temp_s9_ff;
      rsp_in.pressure_pa       = pres_sat[16:0];
      rsp_in.correction_level  = level_s9_ff;
      rsp_in.out_of_range      = tflag_s9_ff | pflag;
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
